>>> rtl/lcdw_pkg.sv
// Shared types and constants for the character LCD writer.
// Used by every module of the block; no dependencies.
package lcdw_pkg;

    typedef enum logic [1:0] {
        FUNC_INIT   = 2'd0,
        FUNC_PLACE  = 2'd1,
        FUNC_NUMBER = 2'd2,
        FUNC_APPEND = 2'd3
    } lcdw_func_t;

    typedef struct packed {
        lcdw_func_t  func;
        logic [7:0]  char_code;
        logic [7:0]  cursor;
        logic [2:0]  len;
    } lcdw_ctl_t;

    localparam logic [7:0]  CMD_SET_DDRAM = 8'h80;
    localparam logic [7:0]  ROW1_OFFSET   = 8'h40;
    localparam logic [3:0]  COL_MAX       = 4'd15;
    localparam logic [7:0]  CMD_FUNC_SET  = 8'h38;
    localparam logic [7:0]  CMD_DISP_ON   = 8'h0C;
    localparam logic [7:0]  CMD_ENTRY     = 8'h06;
    localparam logic [7:0]  CMD_CLEAR     = 8'h01;
    localparam logic [7:0]  ASCII_ZERO    = 8'h30;
    localparam logic [2:0]  INIT_LAST_IDX = 3'd3;
    localparam logic [2:0]  PLACE_LAST_IDX = 3'd1;
    localparam logic [2:0]  APPEND_LAST_IDX = 3'd0;

    // floor(x / 10) == (x * DIV10_MUL) >> DIV10_SHIFT for any x below 2**32
    localparam logic [31:0] DIV10_MUL   = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT = 35;

    function automatic logic [7:0] init_cmd(input logic [1:0] idx);
        logic [7:0] cmd;
        case (idx)
            2'd0:    cmd = CMD_FUNC_SET;
            2'd1:    cmd = CMD_DISP_ON;
            2'd2:    cmd = CMD_ENTRY;
            default: cmd = CMD_CLEAR;
        endcase
        return cmd;
    endfunction

endpackage

>>> rtl/lcdw_front.sv
// Input stage: registers a request, clamps the cursor and digit count.
// Depends on lcdw_pkg.
module lcdw_front #(
    parameter int NUMBER_WIDTH = 16,
    parameter int ND           = 5
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              func,
    input  logic [7:0]              char_code,
    input  logic [NUMBER_WIDTH-1:0] number,
    input  logic [2:0]              digit_count,
    input  logic [7:0]              column,
    input  logic [7:0]              row,
    input  logic                    down_ready,
    output logic                    v_out,
    output lcdw_pkg::lcdw_ctl_t     ctl_out,
    output logic [NUMBER_WIDTH-1:0] num_out
);

    localparam logic [2:0] ND_L = 3'(ND);

    logic                    v_reg;
    lcdw_pkg::lcdw_ctl_t     ctl_reg;
    lcdw_pkg::lcdw_ctl_t     ctl_next;
    logic [NUMBER_WIDTH-1:0] num_reg;
    logic                    ready;
    logic [3:0]              col;

    assign ready    = !v_reg || down_ready;
    assign in_stall = !ready;

    always_comb
    begin
        col = (column > 8'(lcdw_pkg::COL_MAX)) ? lcdw_pkg::COL_MAX : column[3:0];
        ctl_next.func      = lcdw_pkg::lcdw_func_t'(func);
        ctl_next.char_code = char_code;
        ctl_next.cursor    = lcdw_pkg::CMD_SET_DDRAM | {4'd0, col}
                             | ((row != 8'd0) ? lcdw_pkg::ROW1_OFFSET : 8'd0);
        ctl_next.len       = (digit_count > ND_L) ? ND_L : digit_count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (ready)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && in_valid)
        begin
            ctl_reg <= ctl_next;
            num_reg <= number;
        end
    end

    assign v_out   = v_reg;
    assign ctl_out = ctl_reg;
    assign num_out = num_reg;

endmodule

>>> rtl/lcdw_digit_stage.sv
// One pipeline stage of the decimal split: divides by ten, keeps the remainder.
// Depends on lcdw_pkg.
module lcdw_digit_stage #(
    parameter int NUMBER_WIDTH = 16,
    parameter int ND           = 5,
    parameter int SLOT         = 0
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    v_in,
    output logic                    ready_up,
    input  lcdw_pkg::lcdw_ctl_t     ctl_in,
    input  logic [NUMBER_WIDTH-1:0] num_in,
    input  logic [ND*4-1:0]         dig_in,
    input  logic                    down_ready,
    output logic                    v_out,
    output lcdw_pkg::lcdw_ctl_t     ctl_out,
    output logic [NUMBER_WIDTH-1:0] num_out,
    output logic [ND*4-1:0]         dig_out
);

    logic                    v_reg;
    lcdw_pkg::lcdw_ctl_t     ctl_reg;
    logic [NUMBER_WIDTH-1:0] num_reg;
    logic [ND*4-1:0]         dig_reg;
    logic [ND*4-1:0]         dig_next;
    logic [NUMBER_WIDTH+31:0] prod;
    logic [NUMBER_WIDTH+31:0] prod_sh;
    logic [NUMBER_WIDTH-1:0] quot;
    logic [3:0]              rem;

    assign ready_up = !v_reg || down_ready;

    always_comb
    begin
        prod    = (NUMBER_WIDTH+32)'(num_in) * (NUMBER_WIDTH+32)'(lcdw_pkg::DIV10_MUL);
        prod_sh = prod >> lcdw_pkg::DIV10_SHIFT;
        quot    = prod_sh[NUMBER_WIDTH-1:0];
        rem     = num_in[3:0] - ({quot[0], 3'b000} + {quot[2:0], 1'b0});
        dig_next                = dig_in;
        dig_next[SLOT*4 +: 4]   = rem;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (ready_up)
        begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_up && v_in)
        begin
            ctl_reg <= ctl_in;
            num_reg <= quot;
            dig_reg <= dig_next;
        end
    end

    assign v_out   = v_reg;
    assign ctl_out = ctl_reg;
    assign num_out = num_reg;
    assign dig_out = dig_reg;

endmodule

>>> rtl/lcdw_serializer.sv
// Output stage: walks one request's transfers into a registered bus output.
// Depends on lcdw_pkg.
module lcdw_serializer #(
    parameter int ND = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                v_in,
    output logic                ready_up,
    input  lcdw_pkg::lcdw_ctl_t ctl_in,
    input  logic [ND*4-1:0]     dig_in,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                is_data,
    output logic [7:0]          bus_byte,
    output logic                last
);

    localparam int IW = (ND > 1) ? $clog2(ND) : 1;

    logic                busy_reg;
    lcdw_pkg::lcdw_ctl_t ctl_reg;
    logic [ND*4-1:0]     dig_reg;
    logic [2:0]          k_reg;
    logic                out_valid_reg;
    logic                is_data_reg;
    logic [7:0]          byte_reg;
    logic                last_reg;

    logic                out_free;
    logic                emit;
    logic                cur_data;
    logic [7:0]          cur_byte;
    logic                cur_last;
    logic [2:0]          pos;
    logic [IW-1:0]       dsel;
    logic [3:0]          digit;

    always_comb
    begin
        pos   = ctl_reg.len - k_reg;
        dsel  = pos[IW-1:0];
        digit = dig_reg[dsel*4 +: 4];
        cur_data = 1'b1;
        cur_byte = ctl_reg.char_code;
        cur_last = 1'b1;
        unique case (ctl_reg.func)
            lcdw_pkg::FUNC_INIT:
            begin
                cur_data = 1'b0;
                cur_byte = lcdw_pkg::init_cmd(k_reg[1:0]);
                cur_last = (k_reg == lcdw_pkg::INIT_LAST_IDX);
            end
            lcdw_pkg::FUNC_PLACE:
            begin
                cur_data = (k_reg != 3'd0);
                cur_byte = (k_reg == 3'd0) ? ctl_reg.cursor : ctl_reg.char_code;
                cur_last = (k_reg == lcdw_pkg::PLACE_LAST_IDX);
            end
            lcdw_pkg::FUNC_NUMBER:
            begin
                cur_data = (k_reg != 3'd0);
                cur_byte = (k_reg == 3'd0) ? ctl_reg.cursor
                                           : (lcdw_pkg::ASCII_ZERO | {4'd0, digit});
                cur_last = (k_reg == ctl_reg.len);
            end
            lcdw_pkg::FUNC_APPEND:
            begin
                cur_data = 1'b1;
                cur_byte = ctl_reg.char_code;
                cur_last = (k_reg == lcdw_pkg::APPEND_LAST_IDX);
            end
            default:
            begin
                cur_data = 1'b1;
                cur_byte = ctl_reg.char_code;
                cur_last = 1'b1;
            end
        endcase
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign emit     = busy_reg && out_free;
    assign ready_up = !busy_reg || (emit && cur_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            k_reg         <= 3'd0;
        end
        else
        begin
            if (out_free)
            begin
                out_valid_reg <= busy_reg;
            end
            if (ready_up)
            begin
                busy_reg <= v_in;
                k_reg    <= 3'd0;
            end
            else if (emit)
            begin
                k_reg <= k_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_up && v_in)
        begin
            ctl_reg <= ctl_in;
            dig_reg <= dig_in;
        end
        if (emit)
        begin
            is_data_reg <= cur_data;
            byte_reg    <= cur_byte;
            last_reg    <= cur_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign is_data   = is_data_reg;
    assign bus_byte  = byte_reg;
    assign last      = last_reg;

endmodule

>>> rtl/char_lcd_text_and_number_writer_core.sv
// Character LCD writer: requests in, command and data byte transfers out.
// The first transfer of a request passes the input register, the digit stages and the
// serializer registers in that order. The output serializer emits one transfer per cycle
// while out_stall is low (init has 4 transfers, append 1) and takes the next request as
// it emits the last transfer of the current one.
// Reset clears all valid and busy flags; payload registers are not reset.
module char_lcd_text_and_number_writer_core #(
    parameter int NUMBER_WIDTH = 16,
    parameter int MAX_DIGITS   = 5
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              func,
    input  logic [7:0]              char_code,
    input  logic [NUMBER_WIDTH-1:0] number,
    input  logic [2:0]              digit_count,
    input  logic [7:0]              column,
    input  logic [7:0]              row,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    is_data,
    output logic [7:0]              bus_byte,
    output logic                    last
);

    localparam int ND = (MAX_DIGITS > 7) ? 7 : MAX_DIGITS;

    logic                    v_s   [ND+1];
    logic                    rdy_s [ND+1];
    lcdw_pkg::lcdw_ctl_t     ctl_s [ND+1];
    logic [NUMBER_WIDTH-1:0] num_s [ND+1];
    logic [ND*4-1:0]         dig_s [ND+1];

    lcdw_front #(
        .NUMBER_WIDTH (NUMBER_WIDTH),
        .ND           (ND)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .char_code   (char_code),
        .number      (number),
        .digit_count (digit_count),
        .column      (column),
        .row         (row),
        .down_ready  (rdy_s[0]),
        .v_out       (v_s[0]),
        .ctl_out     (ctl_s[0]),
        .num_out     (num_s[0])
    );

    assign dig_s[0] = '0;

    for (genvar i = 0; i < ND; i++)
    begin : g_digit
        lcdw_digit_stage #(
            .NUMBER_WIDTH (NUMBER_WIDTH),
            .ND           (ND),
            .SLOT         (i)
        ) u_stage (
            .clk        (clk),
            .rst_n      (rst_n),
            .v_in       (v_s[i]),
            .ready_up   (rdy_s[i]),
            .ctl_in     (ctl_s[i]),
            .num_in     (num_s[i]),
            .dig_in     (dig_s[i]),
            .down_ready (rdy_s[i+1]),
            .v_out      (v_s[i+1]),
            .ctl_out    (ctl_s[i+1]),
            .num_out    (num_s[i+1]),
            .dig_out    (dig_s[i+1])
        );
    end

    lcdw_serializer #(
        .ND (ND)
    ) u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .v_in      (v_s[ND]),
        .ready_up  (rdy_s[ND]),
        .ctl_in    (ctl_s[ND]),
        .dig_in    (dig_s[ND]),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .is_data   (is_data),
        .bus_byte  (bus_byte),
        .last      (last)
    );

endmodule

>>> dv/tb_top.sv
// Testbench for char_lcd_text_and_number_writer_core: random and directed LCD requests
// are checked transfer by transfer against an in-bench predictor. Depends on lcdw_pkg
// and the core RTL only.
`timescale 1ns / 100ps

module tb_top;

    localparam int NUM_W       = 16;
    localparam int DIGITS_MAX  = 5;
    localparam int RANDOM_REQS = 410;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 24;

    typedef struct packed {
        lcdw_pkg::lcdw_func_t func;
        logic [7:0]         char_code;
        logic [NUM_W-1:0]   number;
        logic [2:0]         digit_count;
        logic [7:0]         column;
        logic [7:0]         row;
    } lcd_req_t;

    typedef struct packed {
        logic       is_data;
        logic [7:0] bus_byte;
        logic       last;
    } lcd_xfer_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    lcdw_pkg::lcdw_func_t req_func = lcdw_pkg::FUNC_INIT;
    logic [7:0]          req_char = 8'd0;
    logic [NUM_W-1:0]    req_number = '0;
    logic [2:0]          req_digits = 3'd0;
    logic [7:0]          req_column = 8'd0;
    logic [7:0]          req_row = 8'd0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                is_data;
    logic [7:0]          bus_byte;
    logic                last;

    lcd_req_t  pending_reqs [$];
    lcd_xfer_t xfers_due [$];
    int        mismatches = 0;
    int        burst_left = 12;
    int        gap_left = 0;
    int        stall_cycle = 0;
    int        hold_left = 0;
    int        cycle_count = 0;
    bit        draining = 1'b0;

    char_lcd_text_and_number_writer_core #(
        .NUMBER_WIDTH(NUM_W),
        .MAX_DIGITS  (DIGITS_MAX)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (req_func),
        .char_code  (req_char),
        .number     (req_number),
        .digit_count(req_digits),
        .column     (req_column),
        .row        (req_row),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .is_data    (is_data),
        .bus_byte   (bus_byte),
        .last       (last)
    );

    always #5 clk = ~clk;

    function automatic lcd_req_t make_req(input lcdw_pkg::lcdw_func_t f,
                                          input logic [7:0] ch,
                                          input logic [NUM_W-1:0] num, input logic [2:0] dc,
                                          input logic [7:0] col, input logic [7:0] rw);
        lcd_req_t r;
        r.func = f;
        r.char_code = ch;
        r.number = num;
        r.digit_count = dc;
        r.column = col;
        r.row = rw;
        return r;
    endfunction

    function automatic lcd_req_t random_req();
        lcdw_pkg::lcdw_func_t f;
        logic [NUM_W-1:0] num;
        logic [7:0] col;
        logic [7:0] rw;
        case ($urandom_range(0, 9))
            0:       f = lcdw_pkg::FUNC_INIT;
            1, 2, 3: f = lcdw_pkg::FUNC_PLACE;
            8, 9:    f = lcdw_pkg::FUNC_APPEND;
            default: f = lcdw_pkg::FUNC_NUMBER;
        endcase
        num = ($urandom_range(0, 3) == 0) ? NUM_W'($urandom_range(0, 99))
                                           : NUM_W'($urandom_range(0, 65535));
        col = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 15));
        rw = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
        return make_req(f, 8'($urandom_range(0, 255)), num, 3'($urandom_range(0, 7)),
                        col, rw);
    endfunction

    function automatic lcd_xfer_t xfer(input logic d, input logic [7:0] b);
        lcd_xfer_t x;
        x.is_data = d;
        x.bus_byte = b;
        x.last = 1'b0;
        return x;
    endfunction

    function automatic logic [7:0] cursor_byte(input logic [7:0] col, input logic [7:0] rw);
        logic [7:0] addr;
        addr = (col > {4'd0, lcdw_pkg::COL_MAX}) ? {4'd0, lcdw_pkg::COL_MAX} : col;
        if (rw != 8'd0)
            addr = addr + lcdw_pkg::ROW1_OFFSET;
        return addr | lcdw_pkg::CMD_SET_DDRAM;
    endfunction

    function automatic void predict_transfers(input lcd_req_t r);
        lcd_xfer_t seq [6];
        int n;
        int len;
        int k;
        int j;
        int unsigned value;
        int unsigned scale;
        n = 0;
        case (r.func)
            lcdw_pkg::FUNC_INIT:
            begin
                seq[0] = xfer(1'b0, lcdw_pkg::CMD_FUNC_SET);
                seq[1] = xfer(1'b0, lcdw_pkg::CMD_DISP_ON);
                seq[2] = xfer(1'b0, lcdw_pkg::CMD_ENTRY);
                seq[3] = xfer(1'b0, lcdw_pkg::CMD_CLEAR);
                n = 4;
            end
            lcdw_pkg::FUNC_PLACE:
            begin
                seq[0] = xfer(1'b0, cursor_byte(r.column, r.row));
                seq[1] = xfer(1'b1, r.char_code);
                n = 2;
            end
            lcdw_pkg::FUNC_NUMBER:
            begin
                seq[0] = xfer(1'b0, cursor_byte(r.column, r.row));
                n = 1;
                value = r.number;
                len = (r.digit_count > DIGITS_MAX) ? DIGITS_MAX : r.digit_count;
                for (k = 0; k < len; k++)
                begin
                    scale = 1;
                    for (j = 0; j < len - 1 - k; j++)
                        scale = scale * 10;
                    seq[n] = xfer(1'b1, lcdw_pkg::ASCII_ZERO + 8'((value / scale) % 10));
                    n++;
                end
            end
            default:
            begin
                seq[0] = xfer(1'b1, r.char_code);
                n = 1;
            end
        endcase
        for (k = 0; k < n; k++)
        begin
            seq[k].last = (k == n - 1);
            xfers_due.push_back(seq[k]);
        end
    endfunction

    // hold the item while stalled, advance on accept, drop valid in gaps
    always @(posedge clk or negedge rst_n)
    begin : drive
        lcd_req_t cur;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (gap_left > 0 || pending_reqs.size() == 0)
            begin
                if (gap_left > 0)
                    gap_left = gap_left - 1;
                in_valid <= 1'b0;
            end
            else
            begin
                cur = pending_reqs.pop_front();
                req_func <= cur.func;
                req_char <= cur.char_code;
                req_number <= cur.number;
                req_digits <= cur.digit_count;
                req_column <= cur.column;
                req_row <= cur.row;
                in_valid <= 1'b1;
                burst_left = burst_left - 1;
                if (burst_left <= 0)
                begin
                    burst_left = ($urandom_range(0, 4) == 0) ? 80 : $urandom_range(1, 20);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            stall_cycle = stall_cycle + 1;
            if (stall_cycle == 1200 || stall_cycle == 3000)
                hold_left = 250;
            if (draining)
                out_stall <= 1'b0;
            else if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                case ((stall_cycle / 40) % 4)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= stall_cycle[0];
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : watch
        lcd_xfer_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                predict_transfers(make_req(req_func, req_char, req_number, req_digits,
                                           req_column, req_row));
            if (out_valid && !out_stall)
            begin
                if (xfers_due.size() == 0)
                begin
                    $display("%0t: unexpected transfer is_data=%0b bus_byte=%02h last=%0b",
                             $time, is_data, bus_byte, last);
                    mismatches++;
                end
                else
                begin
                    want = xfers_due.pop_front();
                    if (is_data !== want.is_data)
                    begin
                        $display("%0t: is_data expected %0b actual %0b",
                                 $time, want.is_data, is_data);
                        mismatches++;
                    end
                    if (bus_byte !== want.bus_byte)
                    begin
                        $display("%0t: bus_byte expected %02h actual %02h",
                                 $time, want.bus_byte, bus_byte);
                        mismatches++;
                    end
                    if (last !== want.last)
                    begin
                        $display("%0t: last expected %0b actual %0b",
                                 $time, want.last, last);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin : stimulus
        int i;
        pending_reqs.push_back(make_req(lcdw_pkg::FUNC_INIT, 8'hFF, 16'hFFFF, 3'd7,
                                        8'hFF, 8'hFF));
        pending_reqs.push_back(make_req(lcdw_pkg::FUNC_PLACE, 8'h00, 16'h0, 3'd0,
                                        8'd0, 8'd0));
        pending_reqs.push_back(make_req(lcdw_pkg::FUNC_PLACE, 8'hFF, 16'hFFFF, 3'd7,
                                        8'd15, 8'd1));
        pending_reqs.push_back(make_req(lcdw_pkg::FUNC_PLACE, 8'h41, 16'h0, 3'd0,
                                        8'd16, 8'hFF));
        pending_reqs.push_back(make_req(lcdw_pkg::FUNC_PLACE, 8'h7E, 16'h0, 3'd0,
                                        8'hFF, 8'h80));
        pending_reqs.push_back(make_req(lcdw_pkg::FUNC_APPEND, 8'h00, 16'hFFFF, 3'd7,
                                        8'hFF, 8'hFF));
        pending_reqs.push_back(make_req(lcdw_pkg::FUNC_APPEND, 8'hFF, 16'h0, 3'd0,
                                        8'd0, 8'd0));
        pending_reqs.push_back(make_req(lcdw_pkg::FUNC_NUMBER, 8'hFF, 16'd0, 3'd0,
                                        8'd3, 8'd0));
        pending_reqs.push_back(make_req(lcdw_pkg::FUNC_NUMBER, 8'h00, 16'd65535, 3'd5,
                                        8'd15, 8'd1));
        pending_reqs.push_back(make_req(lcdw_pkg::FUNC_NUMBER, 8'h00, 16'd12345, 3'd7,
                                        8'd200, 8'd0));
        pending_reqs.push_back(make_req(lcdw_pkg::FUNC_NUMBER, 8'h00, 16'd54321, 3'd6,
                                        8'd0, 8'd2));
        pending_reqs.push_back(make_req(lcdw_pkg::FUNC_NUMBER, 8'h00, 16'd9, 3'd1,
                                        8'd7, 8'd0));
        pending_reqs.push_back(make_req(lcdw_pkg::FUNC_NUMBER, 8'h00, 16'd10, 3'd2,
                                        8'd8, 8'd1));
        pending_reqs.push_back(make_req(lcdw_pkg::FUNC_NUMBER, 8'h00, 16'd65535, 3'd3,
                                        8'd0, 8'd0));
        pending_reqs.push_back(make_req(lcdw_pkg::FUNC_NUMBER, 8'h00, 16'd1, 3'd5,
                                        8'd16, 8'hFF));
        pending_reqs.push_back(make_req(lcdw_pkg::FUNC_NUMBER, 8'h00, 16'd0, 3'd5,
                                        8'd1, 8'd0));
        pending_reqs.push_back(make_req(lcdw_pkg::FUNC_NUMBER, 8'h00, 16'(99999 % 65536),
                                        3'd4, 8'd2, 8'd1));
        pending_reqs.push_back(make_req(lcdw_pkg::FUNC_INIT, 8'h00, 16'h0, 3'd0,
                                        8'd0, 8'd0));
        for (i = 0; i < RANDOM_REQS; i++)
            pending_reqs.push_back(random_req());

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        @(posedge clk);
        while (pending_reqs.size() != 0 || in_valid)
            @(posedge clk);
        while (xfers_due.size() != 0)
            @(posedge clk);
        draining = 1'b1;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> char_lcd_text_and_number_writer_core.f
rtl/lcdw_pkg.sv
rtl/lcdw_front.sv
rtl/lcdw_digit_stage.sv
rtl/lcdw_serializer.sv
rtl/char_lcd_text_and_number_writer_core.sv
dv/tb_top.sv
